// ----- design/utf8_stream_decoder_core_assert.svh -----
// Assertion macros shared by the checker of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define U8SD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define U8SD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder assertion failed");

// Next-cycle implication that also holds across reset.
`define U8SD_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("utf8 decoder assertion failed");

`endif

// ----- design/utf8sd_pkg.sv -----
// Shared types, constants and helpers of the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam int CmdDepth = 4;
    localparam int CmdAw    = $clog2(CmdDepth);

    localparam logic [20:0] SpaceCode = 21'd32;
    localparam logic [20:0] CpMin2    = 21'h00080;
    localparam logic [20:0] CpMin3    = 21'h00800;
    localparam logic [20:0] SurLo     = 21'h0D800;
    localparam logic [20:0] SurHi     = 21'h0DFFF;
    localparam logic [20:0] CpMin4    = 21'h10000;
    localparam logic [20:0] CpMax     = 21'h10FFFF;

    // One command from the front: a run of replacement spaces followed by
    // an optional final result (a code point or the end marker).
    typedef struct packed {
        logic [2:0]  spaces;
        logic        tail;
        logic [20:0] tail_cp;
        logic [2:0]  tail_cnt;
        logic        tail_eot;
    } t_cmd;

    // Sequence length announced by a lead byte, 0 when it is no lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

// ----- design/utf8sd_front.sv -----
// Front end: classifies each byte, holds a partial sequence, issues commands.
module utf8sd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    output logic              o_cmd_valid,
    output utf8sd_pkg::t_cmd  o_cmd
);

    logic [1:0] r_pcount, n_pcount;
    logic [2:0] r_elen, n_elen;
    logic [7:0] r_pend [3];
    logic [7:0] n_pend [3];

    logic             is_cont;
    logic [2:0]       flen;
    logic [2:0]       pre;
    logic             do_fresh;
    logic [20:0]      cp;
    logic             cp_ok;
    utf8sd_pkg::t_cmd cmd;
    logic             cmd_valid;

    assign is_cont = (i_data_byte & 8'hC0) == 8'h80;
    assign flen    = utf8sd_pkg::lead_len(i_data_byte);

    // Code point of a completed sequence, the new byte being the last one.
    always_comb begin
        cp    = '0;
        cp_ok = 1'b0;
        unique case (r_elen)
            3'd2: begin
                cp    = {10'd0, r_pend[0][4:0], i_data_byte[5:0]};
                cp_ok = cp >= utf8sd_pkg::CpMin2;
            end
            3'd3: begin
                cp    = {5'd0, r_pend[0][3:0], r_pend[1][5:0], i_data_byte[5:0]};
                cp_ok = (cp >= utf8sd_pkg::CpMin3) &&
                        !((cp >= utf8sd_pkg::SurLo) && (cp <= utf8sd_pkg::SurHi));
            end
            3'd4: begin
                cp    = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0],
                         i_data_byte[5:0]};
                cp_ok = (cp >= utf8sd_pkg::CpMin4) && (cp <= utf8sd_pkg::CpMax);
            end
            default: begin
                cp    = '0;
                cp_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_pcount  = r_pcount;
        n_elen    = r_elen;
        n_pend    = r_pend;
        cmd       = '0;
        cmd_valid = 1'b0;
        do_fresh  = 1'b0;
        pre       = 3'd0;
        if (i_take) begin
            if (r_pcount == 2'd0) begin
                do_fresh = 1'b1;
            end else if (!is_cont) begin
                // The held lead fails; it and its continuation bytes turn
                // into spaces before the new byte is decoded on its own.
                do_fresh = 1'b1;
                pre      = {1'b0, r_pcount};
            end else if (({1'b0, r_pcount} + 3'd1) < r_elen) begin
                n_pend[r_pcount] = i_data_byte;
                n_pcount         = r_pcount + 2'd1;
            end else begin
                n_pcount  = 2'd0;
                n_elen    = 3'd0;
                cmd_valid = 1'b1;
                if (cp_ok) begin
                    cmd.tail     = 1'b1;
                    cmd.tail_cp  = cp;
                    cmd.tail_cnt = r_elen;
                end else begin
                    cmd.spaces = r_elen;
                end
            end

            if (do_fresh) begin
                n_pcount   = 2'd0;
                n_elen     = 3'd0;
                cmd.spaces = pre;
                if (i_data_byte == 8'd0) begin
                    cmd.tail     = 1'b1;
                    cmd.tail_eot = 1'b1;
                end else if (!i_data_byte[7]) begin
                    cmd.tail     = 1'b1;
                    cmd.tail_cp  = {13'd0, i_data_byte};
                    cmd.tail_cnt = 3'd1;
                end else if (flen == 3'd0) begin
                    cmd.spaces = pre + 3'd1;
                end else begin
                    n_pend[0] = i_data_byte;
                    n_pcount  = 2'd1;
                    n_elen    = flen;
                end
                cmd_valid = (cmd.spaces != 3'd0) || cmd.tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 2'd0;
            r_elen   <= 3'd0;
        end else begin
            r_pcount <= n_pcount;
            r_elen   <= n_elen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    assign o_cmd_valid = cmd_valid;
    assign o_cmd       = cmd;

endmodule

// ----- design/utf8sd_cmd_fifo.sv -----
// Short command queue between the front end and the result expander.
module utf8sd_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  utf8sd_pkg::t_cmd  i_wr_cmd,
    input  logic              i_rd,
    output utf8sd_pkg::t_cmd  o_rd_cmd,
    output logic              o_full,
    output logic              o_nempty
);

    utf8sd_pkg::t_cmd r_mem [utf8sd_pkg::CmdDepth];
    logic [utf8sd_pkg::CmdAw-1:0] r_wp, r_rp;
    logic [utf8sd_pkg::CmdAw:0]   r_cnt;

    logic do_wr, do_rd;

    assign o_full   = r_cnt == (utf8sd_pkg::CmdAw+1)'(utf8sd_pkg::CmdDepth);
    assign o_nempty = r_cnt != '0;
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_nempty;
    assign o_rd_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

endmodule

// ----- design/utf8sd_back.sv -----
// Back end: expands each command into result words, one per pop.
module utf8sd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_avail,
    input  utf8sd_pkg::t_cmd  i_cmd,
    output logic              o_cmd_take,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [20:0]       o_code_point,
    output logic [2:0]        o_byte_count,
    output logic              o_bad_sequence,
    output logic              o_end_of_text,
    output logic              o_last_of_run
);

    logic             r_valid;
    utf8sd_pkg::t_cmd r_cmd;

    logic is_space;
    logic is_last;
    logic load;

    assign is_space = r_cmd.spaces != 3'd0;
    assign is_last  = !is_space || ((r_cmd.spaces == 3'd1) && !r_cmd.tail);
    assign load     = !r_valid || (i_pop && is_last);
    assign o_cmd_take = load && i_cmd_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_cmd_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end else if (i_pop) begin
            r_cmd.spaces <= r_cmd.spaces - 3'd1;
        end
    end

    assign o_empty        = !r_valid;
    assign o_code_point   = is_space ? utf8sd_pkg::SpaceCode : r_cmd.tail_cp;
    assign o_byte_count   = is_space ? 3'd1 : r_cmd.tail_cnt;
    assign o_bad_sequence = is_space;
    assign o_end_of_text  = !is_space && r_cmd.tail_eot;
    assign o_last_of_run  = is_last;

endmodule

// ----- design/utf8_stream_decoder_core.sv -----
// Top level of the strict UTF-8 stream decoder.
// Input side is a queue write port: a byte word is taken at a clock edge
// with i_push high and o_full low. A zero byte marks the end of a text.
// Result side is a queue read port: the oldest result word is shown while
// o_empty is low and is removed at an edge with i_pop high.
// Each byte gives zero to four result words: a held lead byte gives none,
// a failed sequence gives one space per buffered byte, a completed valid
// sequence gives one code point, and a zero byte gives an end word with
// code point 0 and byte count 0. o_last_of_run marks the final word a
// byte caused.
// Bytes are taken one per cycle while the four-entry command queue has
// room; results leave at one word per cycle while the reader pops, so
// the words of one byte follow one another. The first result of a byte
// passes the command queue and then the result register to be visible.
// A stalled reader fills the command queue, then o_full rises.
// Synchronous reset empties all queues and drops any partial sequence.
module utf8_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_byte_count,
    output logic        o_bad_sequence,
    output logic        o_end_of_text,
    output logic        o_last_of_run
);

    logic             take;
    logic             cmd_valid;
    utf8sd_pkg::t_cmd cmd_in;
    utf8sd_pkg::t_cmd cmd_out;
    logic             cmd_nempty;
    logic             cmd_take;
    logic             q_full;

    assign take   = i_push && !q_full;
    assign o_full = q_full;

    utf8sd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    utf8sd_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_valid),
        .i_wr_cmd (cmd_in),
        .i_rd     (cmd_take),
        .o_rd_cmd (cmd_out),
        .o_full   (q_full),
        .o_nempty (cmd_nempty)
    );

    utf8sd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_avail    (cmd_nempty),
        .i_cmd          (cmd_out),
        .o_cmd_take     (cmd_take),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_code_point   (o_code_point),
        .o_byte_count   (o_byte_count),
        .o_bad_sequence (o_bad_sequence),
        .o_end_of_text  (o_end_of_text),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- design/utf8sd_checker.sv -----
// Port-level checker of the UTF-8 stream decoder and its bind.
`include "utf8_stream_decoder_core_assert.svh"

module utf8sd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [20:0] o_code_point,
    input logic [2:0]  o_byte_count,
    input logic        o_bad_sequence,
    input logic        o_end_of_text,
    input logic        o_last_of_run
);

    // Nothing is shown right after reset.
    `U8SD_ASSERT_RST(a_reset_empty, !i_rst_n, o_empty)

    // The end word carries no code point, no bytes, and closes its run.
    `U8SD_ASSERT_IMP(a_end_word, !o_empty && o_end_of_text,
        o_code_point == 21'd0 && o_byte_count == 3'd0 && o_last_of_run && !o_bad_sequence)

    // A replacement is always a one-byte space.
    `U8SD_ASSERT_IMP(a_bad_word, !o_empty && o_bad_sequence,
        o_code_point == 21'd32 && o_byte_count == 3'd1 && !o_end_of_text)

    // A waiting word stays put until it is popped.
    `U8SD_ASSERT_NXT(a_hold, !o_empty && !i_pop,
        !o_empty && $stable(o_code_point) && $stable(o_byte_count) && $stable(o_last_of_run))

endmodule

bind utf8_stream_decoder_core utf8sd_checker u_checker (.*);
